FILE: hdl/fpq_pkg.sv
package fpq_pkg;

	// field widths of the transaction payloads
	localparam int unsigned TAG_W       = 16;
	localparam int unsigned DUR_W       = 20;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned DELAY_W     = 25;
	localparam int unsigned LEN_W       = 7;
	localparam int unsigned SCALE_OUT_W = 8;

	// action codes of an input transaction
	typedef enum logic [1:0] {
		ACT_ARRIVAL     = 2'd0,
		ACT_FEEDBACK    = 2'd1,
		ACT_SERVICE_END = 2'd2,
		ACT_IGNORED     = 2'd3
	} action_t;

	// register indexes on the apb port (word address)
	localparam logic [1:0] REG_QUEUE_LIMIT = 2'd0;
	localparam logic [1:0] REG_BACKOFF     = 2'd1;
	localparam logic [1:0] REG_RAISE       = 2'd2;

	// register reset values
	localparam logic [LEN_W-1:0]  QUEUE_LIMIT_RST = 7'd64;
	localparam logic [TIME_W-1:0] BACKOFF_RST     = 32'd200000;
	localparam logic [TIME_W-1:0] RAISE_RST       = 32'd100000;

	// divide by ten through a reciprocal, exact for inputs below 2^26
	localparam int unsigned     DR_W        = 24;
	localparam int unsigned     QUOT_W      = 21;
	localparam int unsigned     DIV10_SHIFT = 27;
	localparam int unsigned     PROD_W      = 48;
	localparam logic [DR_W-1:0] DIV10_MUL   = 24'd13421773;

	// result flags that travel alongside the delay datapath
	typedef struct packed {
		logic                   sent;
		logic                   start_now;
		logic                   dropped;
		logic [LEN_W-1:0]       qlen;
		logic [SCALE_OUT_W-1:0] scale;
	} flags_t;

endpackage

FILE: hdl/fpq_delay.sv
module fpq_delay #(
	parameter int unsigned TENS_W = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               valid_s2,
	input  fpq_pkg::flags_t                    flags_s2,
	input  logic [fpq_pkg::TAG_W-1:0]          tag_s2,
	input  logic [fpq_pkg::DUR_W-1:0]          dur_s2,
	input  logic [TENS_W-1:0]                  tens_s2,
	input  logic [3:0]                         ones_s2,
	output logic                               valid_s4,
	output fpq_pkg::flags_t                    flags_s4,
	output logic [fpq_pkg::TAG_W-1:0]          tag_s4,
	output logic [fpq_pkg::DELAY_W-1:0]        base_s4,
	output logic [fpq_pkg::QUOT_W-1:0]         quot_s4
);

	localparam int unsigned DELAY_W = fpq_pkg::DELAY_W;
	localparam int unsigned DR_W    = fpq_pkg::DR_W;
	localparam int unsigned PROD_W  = fpq_pkg::PROD_W;

	logic                        valid_s3;
	fpq_pkg::flags_t             flags_s3;
	logic [fpq_pkg::TAG_W-1:0]   tag_s3;
	logic [fpq_pkg::DUR_W-1:0]   dur_s3;
	logic [DELAY_W-1:0]          dq_s3;
	logic [DR_W-1:0]             dr_s3;

	logic [DELAY_W-1:0]          dq;
	logic [DR_W-1:0]             dr;
	logic [DELAY_W-1:0]          base;
	logic [PROD_W-1:0]           prod;

	// duration times tens digit and times ones digit of the scale
	assign dq = DELAY_W'(dur_s2) * DELAY_W'(tens_s2);
	assign dr = DR_W'(dur_s2) * DR_W'(ones_s2);

	// base term d + d*tens, and the ones part divided by ten
	assign base = DELAY_W'(dur_s3) + dq_s3;
	assign prod = PROD_W'(dr_s3) * PROD_W'(fpq_pkg::DIV10_MUL);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s3 <= flags_s2;
			tag_s3   <= tag_s2;
			dur_s3   <= dur_s2;
			dq_s3    <= dq;
			dr_s3    <= dr;
			flags_s4 <= flags_s3;
			tag_s4   <= tag_s3;
			base_s4  <= base;
			quot_s4  <= prod[fpq_pkg::DIV10_SHIFT +: fpq_pkg::QUOT_W];
		end
	end

endmodule

FILE: hdl/feedback_paced_drop_tail_queue_top.sv
// Feedback-paced drop-tail transmit queue.
// Input channel (item_valid / item_stall) carries one event per transaction:
// a packet arrival, congestion feedback, or a service end. Every event gives
// exactly one result transaction on the result channel (result_valid /
// result_stall): the sent packet and its stretched service delay, the
// start-service request, the drop flag, the queue length and the scale.
// An accepted event passes the input, stage 2, stage 3, stage 4 and result
// registers in order; one event is accepted per cycle while the result is not
// stalled. The rate is set by the queue state update (pointers, count, scale
// counter), done on the input register, with the packet store read on the
// same edge; the delay multiply follows in pipelined stages 3 and 4.
// When the result is stalled the whole pipeline holds and item_stall rises
// in the same cycle; results are never lost or reordered.
// Reset empties the queue, clears the scale and the congestion time, and
// loads the register defaults (limit 64, backoff 200000, raise 100000).
// The packet store itself is not cleared; no clearing pass is needed.
// Registers on the apb port: 0x0 queue_limit, 0x4 backoff_interval,
// 0x8 raise_interval; write them only while the block is idle.
module feedback_paced_drop_tail_queue_top #(
	parameter int unsigned QUEUE_DEPTH = 64,
	parameter int unsigned SCALE_MAX   = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// event channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  action,
	input  logic [31:0] now_time,
	input  logic [15:0] packet_tag,
	input  logic [19:0] packet_duration,
	input  logic        queue_full_flag,
	input  logic        receiver_full_flag,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic        sent_valid,
	output logic [15:0] sent_tag,
	output logic [24:0] service_delay,
	output logic        start_service_now,
	output logic        dropped,
	output logic [6:0]  queue_length,
	output logic [7:0]  scale_tenths
);

	localparam int unsigned PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned CMP_W    = (CNT_W > fpq_pkg::LEN_W) ? CNT_W : fpq_pkg::LEN_W;
	localparam int unsigned SCALE_W  = $clog2(SCALE_MAX + 1);
	localparam int unsigned TENS_MAX = SCALE_MAX / 10;
	localparam int unsigned TENS_W   = (TENS_MAX > 0) ? $clog2(TENS_MAX + 1) : 1;
	localparam int unsigned LEN_W    = fpq_pkg::LEN_W;
	localparam int unsigned SOUT_W   = fpq_pkg::SCALE_OUT_W;
	localparam int unsigned TAG_W    = fpq_pkg::TAG_W;
	localparam int unsigned DUR_W    = fpq_pkg::DUR_W;
	localparam int unsigned TIME_W   = fpq_pkg::TIME_W;
	localparam int unsigned DELAY_W  = fpq_pkg::DELAY_W;

	localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(QUEUE_DEPTH);
	localparam logic [SCALE_W-1:0] SCALE_TOP = SCALE_W'(SCALE_MAX);

	// configuration registers
	logic [LEN_W-1:0]  limit_q;
	logic [TIME_W-1:0] backoff_q;
	logic [TIME_W-1:0] raise_q;
	logic              cfg_wr;

	// queue and pacing state
	logic [TAG_W-1:0]   tag_mem [QUEUE_DEPTH];
	logic [DUR_W-1:0]   dur_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;
	logic               busy_q;
	logic [SCALE_W-1:0] scale_q;
	logic [TENS_W-1:0]  tens_q;
	logic [3:0]         ones_q;
	logic [TIME_W-1:0]  last_q;

	// input register
	logic              valid_s1;
	logic [1:0]        act_s1;
	logic [TIME_W-1:0] now_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [DUR_W-1:0]  dur_s1;
	logic              qf_s1;
	logic              rf_s1;

	// step decode
	logic               adv;
	logic               proc;
	logic [TIME_W-1:0]  elapsed;
	logic               act_live;
	logic               dec;
	logic               raise_hit;
	logic               inc;
	logic               pop;
	logic               go_idle;
	logic               push;
	logic               drop;
	logic               start;
	logic [SCALE_W-1:0] scale_d;
	logic [SCALE_W-1:0] scale_n;
	logic [TENS_W-1:0]  tens_d;
	logic [TENS_W-1:0]  tens_n;
	logic [3:0]         ones_d;
	logic [3:0]         ones_n;
	logic [CNT_W-1:0]   count_n;

	// stage 2
	logic              valid_s2;
	fpq_pkg::flags_t   flags_s2;
	logic [TAG_W-1:0]  tag_s2;
	logic [DUR_W-1:0]  dur_s2;
	logic [TENS_W-1:0] tens_s2;
	logic [3:0]        ones_s2;

	// stage 4 from the delay datapath
	logic                       valid_s4;
	fpq_pkg::flags_t            flags_s4;
	logic [TAG_W-1:0]           tag_s4;
	logic [DELAY_W-1:0]         base_s4;
	logic [fpq_pkg::QUOT_W-1:0] quot_s4;

	// result register
	logic               result_valid_q;
	logic               sent_q;
	logic [TAG_W-1:0]   sent_tag_q;
	logic [DELAY_W-1:0] delay_q;
	logic               start_q;
	logic               dropped_q;
	logic [LEN_W-1:0]   qlen_q;
	logic [SOUT_W-1:0]  scale_out_q;

	// apb access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= fpq_pkg::QUEUE_LIMIT_RST;
			backoff_q <= fpq_pkg::BACKOFF_RST;
			raise_q   <= fpq_pkg::RAISE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				fpq_pkg::REG_QUEUE_LIMIT: limit_q   <= pwdata[LEN_W-1:0];
				fpq_pkg::REG_BACKOFF:     backoff_q <= pwdata;
				fpq_pkg::REG_RAISE:       raise_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			fpq_pkg::REG_QUEUE_LIMIT: prdata = 32'(limit_q);
			fpq_pkg::REG_BACKOFF:     prdata = backoff_q;
			fpq_pkg::REG_RAISE:       prdata = raise_q;
			default:                  prdata = 32'd0;
		endcase
	end

	// the whole pipeline moves unless a finished result is held
	assign adv        = !result_valid_q || !result_stall;
	assign item_stall = !adv;
	assign proc       = valid_s1 && adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= action;
			now_s1 <= now_time;
			tag_s1 <= packet_tag;
			dur_s1 <= packet_duration;
			qf_s1  <= queue_full_flag;
			rf_s1  <= receiver_full_flag;
		end
	end

	// event decode and scale update, scale kept also as tens and ones digits
	always_comb begin
		elapsed   = now_s1 - last_q;
		act_live  = act_s1 != fpq_pkg::ACT_IGNORED;
		dec       = act_live && (elapsed >= backoff_q) && (scale_q > SCALE_W'(1));
		raise_hit = (act_s1 == fpq_pkg::ACT_FEEDBACK) && (qf_s1 || rf_s1) &&
			(elapsed >= raise_q);

		scale_d = scale_q;
		tens_d  = tens_q;
		ones_d  = ones_q;
		if (dec) begin
			scale_d = scale_q - SCALE_W'(1);
			if (ones_q == 4'd0) begin
				ones_d = 4'd9;
				tens_d = tens_q - TENS_W'(1);
			end else begin
				ones_d = ones_q - 4'd1;
			end
		end

		inc     = raise_hit && (scale_d < SCALE_TOP);
		scale_n = scale_d;
		tens_n  = tens_d;
		ones_n  = ones_d;
		if (inc) begin
			scale_n = scale_d + SCALE_W'(1);
			if (ones_d == 4'd9) begin
				ones_n = 4'd0;
				tens_n = tens_d + TENS_W'(1);
			end else begin
				ones_n = ones_d + 4'd1;
			end
		end

		pop     = (act_s1 == fpq_pkg::ACT_SERVICE_END) && (count_q != '0);
		go_idle = (act_s1 == fpq_pkg::ACT_SERVICE_END) && (count_q == '0);
		drop    = (act_s1 == fpq_pkg::ACT_ARRIVAL) &&
			((CMP_W'(count_q) >= CMP_W'(limit_q)) || (count_q == CNT_FULL));
		push    = (act_s1 == fpq_pkg::ACT_ARRIVAL) && !drop;
		start   = push && !busy_q;

		if (push) begin
			count_n = count_q + CNT_W'(1);
		end else if (pop) begin
			count_n = count_q - CNT_W'(1);
		end else begin
			count_n = count_q;
		end
	end

	// queue and pacing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			busy_q  <= 1'b0;
			scale_q <= '0;
			tens_q  <= '0;
			ones_q  <= 4'd0;
			last_q  <= '0;
		end else if (proc) begin
			count_q <= count_n;
			scale_q <= scale_n;
			tens_q  <= tens_n;
			ones_q  <= ones_n;
			if (raise_hit) begin
				last_q <= now_s1;
			end
			if (pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
				busy_q <= 1'b1;
			end else if (go_idle) begin
				busy_q <= 1'b0;
			end
			if (push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
				if (start) begin
					busy_q <= 1'b1;
				end
			end
		end
	end

	// packet store: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (proc && push) begin
			tag_mem[tail_q] <= tag_s1;
			dur_mem[tail_q] <= dur_s1;
		end
		if (adv) begin
			tag_s2 <= tag_mem[head_q];
			dur_s2 <= dur_mem[head_q];
		end
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s2.sent      <= act_live && pop;
			flags_s2.start_now <= start;
			flags_s2.dropped   <= drop;
			flags_s2.qlen      <= LEN_W'(act_live ? count_n : count_q);
			flags_s2.scale     <= SOUT_W'(scale_n);
			tens_s2            <= tens_n;
			ones_s2            <= ones_n;
		end
	end

	// delay = d + d*tens + floor(d*ones / 10)
	fpq_delay #(
		.TENS_W(TENS_W)
	) u_delay (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s2 (valid_s2),
		.flags_s2 (flags_s2),
		.tag_s2   (tag_s2),
		.dur_s2   (dur_s2),
		.tens_s2  (tens_s2),
		.ones_s2  (ones_s2),
		.valid_s4 (valid_s4),
		.flags_s4 (flags_s4),
		.tag_s4   (tag_s4),
		.base_s4  (base_s4),
		.quot_s4  (quot_s4)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sent_q      <= flags_s4.sent;
			sent_tag_q  <= flags_s4.sent ? tag_s4 : '0;
			delay_q     <= flags_s4.sent ? base_s4 + DELAY_W'(quot_s4) : '0;
			start_q     <= flags_s4.start_now;
			dropped_q   <= flags_s4.dropped;
			qlen_q      <= flags_s4.qlen;
			scale_out_q <= flags_s4.scale;
		end
	end

	assign result_valid      = result_valid_q;
	assign sent_valid        = sent_q;
	assign sent_tag          = sent_tag_q;
	assign service_delay     = delay_q;
	assign start_service_now = start_q;
	assign dropped           = dropped_q;
	assign queue_length      = qlen_q;
	assign scale_tenths      = scale_out_q;

endmodule

FILE: hdl/fpq_chk.sv
module fpq_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        sent_valid,
	input logic [15:0] sent_tag,
	input logic [24:0] service_delay,
	input logic        start_service_now,
	input logic        dropped,
	input logic [6:0]  queue_length
);

	// a stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(sent_tag) && $stable(service_delay))
		else $error("result changed while stalled");

	// nothing sent means empty tag and delay
	a_idle_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !sent_valid |-> sent_tag == 16'd0 && service_delay == 25'd0)
		else $error("payload present without a sent packet");

	// one event gives at most one of send, start and drop
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0({sent_valid, start_service_now, dropped}))
		else $error("more than one outcome in a result");

	// a start request follows a stored packet
	a_start_stored: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && start_service_now |-> queue_length != 7'd0)
		else $error("start request with an empty queue");

	// no result during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind feedback_paced_drop_tail_queue_top fpq_chk u_fpq_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.result_valid      (result_valid),
	.result_stall      (result_stall),
	.sent_valid        (sent_valid),
	.sent_tag          (sent_tag),
	.service_delay     (service_delay),
	.start_service_now (start_service_now),
	.dropped           (dropped),
	.queue_length      (queue_length)
);

FILE: sim/feedback_paced_drop_tail_queue_top_tb.sv
module feedback_paced_drop_tail_queue_top_tb;

	localparam int unsigned DEPTH         = 64;
	localparam int unsigned SCALE_CAP     = 255;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned REPORT_MAX    = 10;

	// one result transaction as seen on the result channel
	typedef struct packed {
		logic                            sent;
		logic [fpq_pkg::TAG_W-1:0]       tag;
		logic [fpq_pkg::DELAY_W-1:0]     delay;
		logic                            start_now;
		logic                            dropped;
		logic [fpq_pkg::LEN_W-1:0]       qlen;
		logic [fpq_pkg::SCALE_OUT_W-1:0] scale;
	} send_report_t;

	// shadow of the paced queue plus the reports it should produce
	class pacing_scoreboard;
		logic [fpq_pkg::TAG_W-1:0]  tag_mem [DEPTH];
		logic [fpq_pkg::DUR_W-1:0]  dur_mem [DEPTH];
		int unsigned                rd_ptr, wr_ptr, held;
		bit                         busy;
		int unsigned                scale;
		logic [fpq_pkg::TIME_W-1:0] last_congestion;
		int unsigned                limit;
		logic [fpq_pkg::TIME_W-1:0] backoff, raise_gap;
		send_report_t               expected_reports[$];
		int unsigned       mismatches, checked, sends, drops, starts, peak_len, peak_scale;

		function new();
			rd_ptr = 0;
			wr_ptr = 0;
			held = 0;
			busy = 0;
			scale = 0;
			last_congestion = '0;
			limit = fpq_pkg::QUEUE_LIMIT_RST;
			backoff = fpq_pkg::BACKOFF_RST;
			raise_gap = fpq_pkg::RAISE_RST;
		endfunction

		function void apply_register(logic [1:0] idx, logic [31:0] val);
			case (idx)
			fpq_pkg::REG_QUEUE_LIMIT: limit = val[fpq_pkg::LEN_W-1:0];
			fpq_pkg::REG_BACKOFF:     backoff = val;
			fpq_pkg::REG_RAISE:       raise_gap = val;
			default: ;
			endcase
		endfunction

		// predict the report of one accepted event transaction
		function void note_event(fpq_pkg::action_t act, logic [fpq_pkg::TIME_W-1:0] t,
				logic [fpq_pkg::TAG_W-1:0] tag, logic [fpq_pkg::DUR_W-1:0] dur,
				logic qf, logic rf);
			send_report_t               r;
			logic [fpq_pkg::TIME_W-1:0] elapsed;
			longint unsigned            stretched;
			r = '0;
			if (act != fpq_pkg::ACT_IGNORED) begin
				elapsed = t - last_congestion;
				// decay once the backoff has run out
				if (elapsed >= backoff && scale > 1)
					scale--;
				case (act)
				fpq_pkg::ACT_FEEDBACK: begin
					if ((qf || rf) && elapsed >= raise_gap) begin
						if (scale < SCALE_CAP)
							scale++;
						last_congestion = t;
					end
				end
				fpq_pkg::ACT_SERVICE_END: begin
					if (held > 0) begin
						r.sent = 1'b1;
						r.tag = tag_mem[rd_ptr];
						stretched = longint'(dur_mem[rd_ptr]) * (10 + scale) / 10;
						r.delay = stretched[fpq_pkg::DELAY_W-1:0];
						rd_ptr = (rd_ptr + 1 >= DEPTH) ? 0 : rd_ptr + 1;
						held--;
						busy = 1'b1;
						sends++;
					end else begin
						busy = 1'b0;
					end
				end
				default: begin
					// drop tail at the limit or when physically full
					if (held >= limit || held >= DEPTH) begin
						r.dropped = 1'b1;
						drops++;
					end else begin
						tag_mem[wr_ptr] = tag;
						dur_mem[wr_ptr] = dur;
						wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
						held++;
						if (!busy) begin
							busy = 1'b1;
							r.start_now = 1'b1;
							starts++;
						end
					end
				end
				endcase
			end
			r.qlen = held[fpq_pkg::LEN_W-1:0];
			r.scale = scale[fpq_pkg::SCALE_OUT_W-1:0];
			if (held > peak_len)
				peak_len = held;
			if (scale > peak_scale)
				peak_scale = scale;
			expected_reports.push_back(r);
		endfunction

		// compare one result transaction with the oldest prediction
		function void check_report(send_report_t got);
			send_report_t want;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result transaction: sent=%0b tag=%h delay=%0d",
						got.sent, got.tag, got.delay);
				return;
			end
			want = expected_reports.pop_front();
			checked++;
			if (got.sent !== want.sent || got.tag !== want.tag || got.delay !== want.delay ||
					got.start_now !== want.start_now || got.dropped !== want.dropped ||
					got.qlen !== want.qlen || got.scale !== want.scale) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("mismatch on result %0d", checked);
					$display("  expected sent=%0b tag=%h delay=%0d start=%0b drop=%0b len=%0d scale=%0d",
						want.sent, want.tag, want.delay, want.start_now, want.dropped,
						want.qlen, want.scale);
					$display("  actual   sent=%0b tag=%h delay=%0d start=%0b drop=%0b len=%0d scale=%0d",
						got.sent, got.tag, got.delay, got.start_now, got.dropped,
						got.qlen, got.scale);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        item_valid, item_stall;
	logic [1:0]  action;
	logic [31:0] now_time;
	logic [15:0] packet_tag;
	logic [19:0] packet_duration;
	logic        queue_full_flag, receiver_full_flag;
	logic        result_valid, result_stall;
	logic        sent_valid;
	logic [15:0] sent_tag;
	logic [24:0] service_delay;
	logic        start_service_now, dropped;
	logic [6:0]  queue_length;
	logic [7:0]  scale_tenths;

	pacing_scoreboard           sb;
	int unsigned                send_idle_pct, stall_pct, hold_request, hold_left, cycle_count;
	int unsigned                ignored_events;
	logic [fpq_pkg::TIME_W-1:0] clock_base;

	feedback_paced_drop_tail_queue_top #(
		.QUEUE_DEPTH(DEPTH),
		.SCALE_MAX  (SCALE_CAP)
	) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.action            (action),
		.now_time          (now_time),
		.packet_tag        (packet_tag),
		.packet_duration   (packet_duration),
		.queue_full_flag   (queue_full_flag),
		.receiver_full_flag(receiver_full_flag),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.sent_valid        (sent_valid),
		.sent_tag          (sent_tag),
		.service_delay     (service_delay),
		.start_service_now (start_service_now),
		.dropped           (dropped),
		.queue_length      (queue_length),
		.scale_tenths      (scale_tenths)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL feedback_paced_drop_tail_queue_top");
		$finish;
	end

	// result side: check, random stalls, long hold-off on request
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				sb.check_report({sent_valid, sent_tag, service_delay, start_service_now,
					dropped, queue_length, scale_tenths});
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// offer one event transaction and wait until it is taken
	task automatic offer_event(input fpq_pkg::action_t act,
			input logic [fpq_pkg::TIME_W-1:0] t, input logic [fpq_pkg::TAG_W-1:0] tag,
			input logic [fpq_pkg::DUR_W-1:0] dur, input logic qf, input logic rf);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		now_time <= t;
		packet_tag <= tag;
		packet_duration <= dur;
		queue_full_flag <= qf;
		receiver_full_flag <= rf;
		do @(posedge clk); while (item_stall);
		sb.note_event(act, t, tag, dur, qf, rf);
		if (act == fpq_pkg::ACT_IGNORED)
			ignored_events++;
	endtask

	// apb write: setup then access
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.apply_register(idx, val);
	endtask

	// let every outstanding result drain, then idle before the next phase
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random traffic with a given event mix and time advance
	task automatic run_phase(input int unsigned items, input int unsigned w_arr,
			input int unsigned w_fb, input int unsigned step_max);
		int unsigned                done, pick;
		fpq_pkg::action_t           act;
		logic [fpq_pkg::TIME_W-1:0] t;
		logic [1:0]                 flags;
		done = 0;
		while (done < items) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				act = fpq_pkg::ACT_IGNORED;
			end else begin
				pick = $urandom_range(99);
				if (pick < w_arr)
					act = fpq_pkg::ACT_ARRIVAL;
				else if (pick < w_arr + w_fb)
					act = fpq_pkg::ACT_FEEDBACK;
				else
					act = fpq_pkg::ACT_SERVICE_END;
			end
			clock_base += $urandom_range(step_max);
			// occasional wild timestamp to exercise wraparound
			t = ($urandom_range(19) == 0) ? $urandom() : clock_base;
			flags = ($urandom_range(15) == 0) ? 2'b00 : 2'($urandom_range(3, 1));
			offer_event(act, t, 16'($urandom()), 20'($urandom()), flags[1], flags[0]);
			if (act != fpq_pkg::ACT_IGNORED)
				done++;
		end
	endtask

	// main sequence
	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_valid <= 1'b0;
		action <= fpq_pkg::ACT_ARRIVAL;
		now_time <= '0;
		packet_tag <= '0;
		packet_duration <= '0;
		queue_full_flag <= 1'b0;
		receiver_full_flag <= 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle service end, field extremes, raises, decay, wrap
		offer_event(fpq_pkg::ACT_SERVICE_END, 32'd0, 16'h1234, 20'h00000, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_ARRIVAL, 32'd10, 16'h0000, 20'h00000, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_ARRIVAL, 32'd20, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b1);
		offer_event(fpq_pkg::ACT_FEEDBACK, 32'd30, 16'h5A5A, 20'h5A5A5, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_FEEDBACK, 32'd100000, 16'h0001, 20'h00001, 1'b1, 1'b0);
		offer_event(fpq_pkg::ACT_FEEDBACK, 32'd150000, 16'h0002, 20'h00002, 1'b0, 1'b1);
		offer_event(fpq_pkg::ACT_FEEDBACK, 32'd200000, 16'h0003, 20'h00003, 1'b1, 1'b1);
		offer_event(fpq_pkg::ACT_IGNORED, 32'hA5A5A5A5, 16'hA5A5, 20'hA5A5A, 1'b1, 1'b1);
		offer_event(fpq_pkg::ACT_SERVICE_END, 32'd200010, 16'h0000, 20'h00000, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_SERVICE_END, 32'd200020, 16'h0000, 20'h00000, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_SERVICE_END, 32'd200030, 16'h0000, 20'h00000, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_ARRIVAL, 32'd400000, 16'h8001, 20'h80001, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_ARRIVAL, 32'hFFFFFFFF, 16'h7FFE, 20'h7FFFE, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_FEEDBACK, 32'hFFFFFFFF, 16'h0004, 20'h00004, 1'b1, 1'b0);
		// time wraps: elapsed is exactly the backoff
		offer_event(fpq_pkg::ACT_FEEDBACK, 32'h00030D3F, 16'h0005, 20'h00005, 1'b1, 1'b1);
		offer_event(fpq_pkg::ACT_SERVICE_END, 32'h00030D40, 16'h0000, 20'h00000, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_SERVICE_END, 32'h00030D41, 16'h0000, 20'h00000, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_SERVICE_END, 32'h00030D42, 16'h0000, 20'h00000, 1'b0, 1'b0);
		settle();

		// zero limit drops everything
		write_reg(fpq_pkg::REG_QUEUE_LIMIT, 32'd0);
		offer_event(fpq_pkg::ACT_ARRIVAL, 32'h00030D50, 16'hC0DE, 20'h12345, 1'b0, 1'b0);
		offer_event(fpq_pkg::ACT_ARRIVAL, 32'h00030D60, 16'hBEEF, 20'h54321, 1'b0, 1'b0);
		settle();
		// widest raise interval, reached only one step behind the last raise
		write_reg(fpq_pkg::REG_RAISE, 32'hFFFFFFFF);
		offer_event(fpq_pkg::ACT_FEEDBACK, 32'h00030D3E, 16'h0006, 20'h00006, 1'b0, 1'b1);
		settle();
		clock_base = 32'h00030D3E;

		// back to back, limit above depth, long receiver hold-off to fill the pipe
		write_reg(fpq_pkg::REG_QUEUE_LIMIT, 32'd127);
		write_reg(fpq_pkg::REG_BACKOFF, 32'd50000);
		write_reg(fpq_pkg::REG_RAISE, 32'd20000);
		hold_request = 400;
		run_phase(160, 70, 10, 30000);
		settle();

		// sparse sender, tight limit, decay on every event
		send_idle_pct = 80;
		stall_pct = 0;
		write_reg(fpq_pkg::REG_QUEUE_LIMIT, 32'd5);
		write_reg(fpq_pkg::REG_BACKOFF, 32'd0);
		write_reg(fpq_pkg::REG_RAISE, 32'd0);
		run_phase(100, 35, 30, 5000);
		settle();

		// heavy receiver stall, no decay
		send_idle_pct = 0;
		stall_pct = 80;
		write_reg(fpq_pkg::REG_QUEUE_LIMIT, 32'd64);
		write_reg(fpq_pkg::REG_BACKOFF, 32'hFFFFFFFF);
		write_reg(fpq_pkg::REG_RAISE, 32'd1000);
		run_phase(100, 40, 25, 3000);
		settle();

		// both sides idle, feedback heavy to drive the scale to its cap
		send_idle_pct = 34;
		stall_pct = 34;
		write_reg(fpq_pkg::REG_QUEUE_LIMIT, 32'd40);
		write_reg(fpq_pkg::REG_RAISE, 32'd0);
		run_phase(300, 5, 90, 2000);
		settle();

		$display("checked %0d results (%0d ignored events): %0d sent, %0d dropped, %0d starts",
			sb.checked, ignored_events, sb.sends, sb.drops, sb.starts);
		$display("queue peaked at %0d packets, scale peaked at %0d tenths, %0d mismatches",
			sb.peak_len, sb.peak_scale, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_reports.size() == 0)
			$display("PASS feedback_paced_drop_tail_queue_top");
		else
			$display("FAIL feedback_paced_drop_tail_queue_top");
		$finish;
	end

endmodule

FILE: feedback_paced_drop_tail_queue_top.f
hdl/fpq_pkg.sv
hdl/fpq_delay.sv
hdl/feedback_paced_drop_tail_queue_top.sv
hdl/fpq_chk.sv
sim/feedback_paced_drop_tail_queue_top_tb.sv
